// File: hdl/gct_pkg.sv
package gct_pkg;

  // configuration register indexes (byte address 4*index)
  localparam int unsigned AddrW = 5;
  localparam logic [2:0] RegConfThr     = 3'd0;
  localparam logic [2:0] RegAngleTol    = 3'd1;
  localparam logic [2:0] RegClosedLim   = 3'd2;
  localparam logic [2:0] RegLookTime    = 3'd3;
  localparam logic [2:0] RegAvertTime   = 3'd4;
  localparam logic [2:0] RegImageWidth  = 3'd5;
  localparam logic [2:0] RegAvertOffset = 3'd6;

  // phase codes
  localparam logic [1:0] PhaseIdle    = 2'd0;
  localparam logic [1:0] PhaseContact = 2'd1;
  localparam logic [1:0] PhaseAvert   = 2'd2;
  localparam logic [1:0] PhaseSearch  = 2'd3;

  // observation kinds
  localparam logic [1:0] KindOpen   = 2'd0;
  localparam logic [1:0] KindNoOpen = 2'd1;

  // blink codes
  localparam logic [1:0] BlinkClosed  = 2'd0;
  localparam logic [1:0] BlinkOpen    = 2'd1;
  localparam logic [1:0] BlinkUnknown = 2'd2;

  localparam logic [5:0] SearchLast = 6'd35;
  localparam logic signed [9:0] JitterPos = 10'sd3;
  localparam logic signed [9:0] JitterNeg = -10'sd3;

  // settings used by the classifier
  typedef struct packed {
    logic [9:0]  conf_thr;
    logic [7:0]  angle_tol;
    logic [9:0]  closed_lim;
    logic [11:0] image_width;
  } front_cfg_t;

  // settings used by the phase machine
  typedef struct packed {
    logic [15:0] look_time;
    logic [15:0] avert_time;
    logic [8:0]  avert_offset;
  } back_cfg_t;

  // classified observation, without its score
  typedef struct packed {
    logic        no_face;
    logic        plus_side;
    logic [1:0]  blink;
    logic [15:0] elapsed;
  } obs_t;

  // 200*sin(step*10 deg), truncated toward zero
  function automatic logic signed [9:0] sweep_offset(input logic [5:0] step);
    logic signed [9:0] val;
    case (step)
      6'd0:  val = 10'sd0;
      6'd1:  val = 10'sd34;
      6'd2:  val = 10'sd68;
      6'd3:  val = 10'sd100;
      6'd4:  val = 10'sd128;
      6'd5:  val = 10'sd153;
      6'd6:  val = 10'sd173;
      6'd7:  val = 10'sd187;
      6'd8:  val = 10'sd196;
      6'd9:  val = 10'sd200;
      6'd10: val = 10'sd196;
      6'd11: val = 10'sd187;
      6'd12: val = 10'sd173;
      6'd13: val = 10'sd153;
      6'd14: val = 10'sd128;
      6'd15: val = 10'sd100;
      6'd16: val = 10'sd68;
      6'd17: val = 10'sd34;
      6'd18: val = 10'sd0;
      6'd19: val = -10'sd34;
      6'd20: val = -10'sd68;
      6'd21: val = -10'sd100;
      6'd22: val = -10'sd128;
      6'd23: val = -10'sd153;
      6'd24: val = -10'sd173;
      6'd25: val = -10'sd187;
      6'd26: val = -10'sd196;
      6'd27: val = -10'sd200;
      6'd28: val = -10'sd196;
      6'd29: val = -10'sd187;
      6'd30: val = -10'sd173;
      6'd31: val = -10'sd153;
      6'd32: val = -10'sd128;
      6'd33: val = -10'sd100;
      6'd34: val = -10'sd68;
      6'd35: val = -10'sd34;
      default: val = 10'sd0;
    endcase
    return val;
  endfunction

endpackage

// File: hdl/gct_front.sv
module gct_front #(
  parameter int unsigned WINDOW = 10
) (
  input  logic [1:0]             kind_i,
  input  logic signed [8:0]      face_yaw_i,
  input  logic signed [8:0]      gaze_yaw_i,
  input  logic [9:0]             face_confidence_i,
  input  logic [9:0]             gaze_confidence_i,
  input  logic [9:0]             eye_a_openness_i,
  input  logic [9:0]             eye_a_confidence_i,
  input  logic [9:0]             eye_b_openness_i,
  input  logic [9:0]             eye_b_confidence_i,
  input  logic [11:0]            face_right_edge_i,
  input  logic [11:0]            face_left_edge_i,
  input  logic [15:0]            elapsed_ms_i,
  input  gct_pkg::front_cfg_t    cfg_i,
  output gct_pkg::obs_t          obs_o,
  output logic [$clog2(WINDOW/3+1)-1:0] score_o
);

  localparam int unsigned ScoreW = $clog2(WINDOW / 3 + 1);
  localparam logic [ScoreW-1:0] ScoreOpp = ScoreW'(WINDOW / 3);

  logic              conf_ok;
  logic              opposite;
  logic              straight;
  logic [8:0]        fy_mag, gy_mag, mag_diff;
  logic [11:0]       box_width;
  logic signed [12:0] centre, half_image;
  logic              a_closed, b_closed;

  // yaw magnitudes, 256 fits as unsigned
  assign fy_mag   = face_yaw_i[8] ? 9'(~face_yaw_i + 9'sd1) : 9'(face_yaw_i);
  assign gy_mag   = gaze_yaw_i[8] ? 9'(~gaze_yaw_i + 9'sd1) : 9'(gaze_yaw_i);
  assign mag_diff = (fy_mag >= gy_mag) ? (fy_mag - gy_mag) : (gy_mag - fy_mag);

  // gaze score
  assign conf_ok  = (face_confidence_i > cfg_i.conf_thr) &&
                    (gaze_confidence_i > cfg_i.conf_thr);
  assign opposite = (face_yaw_i[8] && !gaze_yaw_i[8] && (gaze_yaw_i != 9'sd0)) ||
                    (!face_yaw_i[8] && (face_yaw_i != 9'sd0) && gaze_yaw_i[8]);
  assign straight = (fy_mag < {1'b0, cfg_i.angle_tol}) &&
                    (mag_diff < {1'b0, cfg_i.angle_tol});

  always_comb begin
    if (!conf_ok) begin
      score_o = '0;
    end else if (opposite) begin
      score_o = ScoreOpp;
    end else if (straight) begin
      score_o = ScoreW'(1);
    end else begin
      score_o = '0;
    end
  end

  // face side relative to the image center
  assign box_width  = (face_right_edge_i >= face_left_edge_i) ?
                      (face_right_edge_i - face_left_edge_i) :
                      (face_left_edge_i - face_right_edge_i);
  assign centre     = $signed({1'b0, face_right_edge_i}) - $signed({2'b00, box_width[11:1]});
  assign half_image = $signed({2'b00, cfg_i.image_width[11:1]});

  // blink
  assign a_closed = (eye_a_openness_i < cfg_i.closed_lim) &&
                    (eye_a_confidence_i > cfg_i.conf_thr);
  assign b_closed = (eye_b_openness_i < cfg_i.closed_lim) &&
                    (eye_b_confidence_i > cfg_i.conf_thr);

  always_comb begin
    obs_o.no_face   = kind_i[1];
    obs_o.plus_side = centre > half_image;
    obs_o.elapsed   = elapsed_ms_i;
    case (kind_i)
      gct_pkg::KindOpen: obs_o.blink = (a_closed && b_closed) ? gct_pkg::BlinkClosed :
                                                              gct_pkg::BlinkOpen;
      default:           obs_o.blink = gct_pkg::BlinkUnknown;
    endcase
  end

endmodule

// File: hdl/gct_queue.sv
module gct_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign data_o  = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// File: hdl/gct_back.sv
module gct_back #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gct_pkg::back_cfg_t            cfg_i,
  input  logic                          item_valid_i,
  input  gct_pkg::obs_t                 obs_i,
  input  logic [$clog2(WINDOW/3+1)-1:0] score_i,
  output logic                          item_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    phase_o,
  output logic signed [9:0]             eye_offset_o,
  output logic [1:0]                    blink_code_o,
  output logic [4:0]                    vote_sum_o,
  output logic                          contact_o
);

  localparam int unsigned ScoreW = $clog2(WINDOW / 3 + 1);
  localparam int unsigned SumW   = $clog2(WINDOW * (WINDOW / 3) + 1);
  localparam logic [SumW-1:0] HalfWindow = SumW'(WINDOW / 2);

  logic [ScoreW-1:0] win_q [WINDOW];
  logic [ScoreW-1:0] win_d [WINDOW];
  logic [SumW-1:0]   sum_q, sum_d;
  logic [1:0]        phase_q, phase_d;
  logic [15:0]       look_q, look_d, avert_q, avert_d;
  logic              jitter_q, jitter_d;
  logic [5:0]        step_q, step_d, step_use;
  logic              valid_q, valid_d;
  logic              contact;
  logic signed [9:0] offset, jitter, gap;
  logic [16:0]       look_add, avert_add;
  logic [15:0]       look_sat, avert_sat;

  logic [1:0]        phase_out_q;
  logic signed [9:0] offset_q;
  logic [1:0]        blink_q;
  logic [4:0]        vote_q;
  logic              contact_q;

  // take the next word when the output slot is free or drains now
  assign item_pop_o = item_valid_i && (!valid_q || out_ready_i);
  assign valid_d    = item_pop_o || (valid_q && !out_ready_i);

  // saturating dwell counters
  assign look_add  = {1'b0, look_q} + {1'b0, obs_i.elapsed};
  assign avert_add = {1'b0, avert_q} + {1'b0, obs_i.elapsed};
  assign look_sat  = look_add[16] ? 16'hFFFF : look_add[15:0];
  assign avert_sat = avert_add[16] ? 16'hFFFF : avert_add[15:0];

  assign jitter   = jitter_q ? gct_pkg::JitterNeg : gct_pkg::JitterPos;
  assign gap      = obs_i.plus_side ? $signed({1'b0, cfg_i.avert_offset}) :
                                      -$signed({1'b0, cfg_i.avert_offset});
  assign step_use = ((phase_q != gct_pkg::PhaseSearch) || (step_q > gct_pkg::SearchLast)) ?
                    6'd0 : step_q;

  // window shift and running sum
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      win_d[i] = win_q[i];
    end
    sum_d = sum_q;
    if (!obs_i.no_face) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[WINDOW-1] = score_i;
      sum_d = SumW'(sum_q - SumW'(win_q[0]) + SumW'(score_i));
    end
  end

  assign contact = sum_d > HalfWindow;

  // phase machine and eye offset
  always_comb begin
    phase_d  = phase_q;
    look_d   = look_q;
    avert_d  = avert_q;
    jitter_d = jitter_q;
    step_d   = step_q;
    offset   = jitter;
    if (obs_i.no_face) begin
      phase_d = gct_pkg::PhaseSearch;
      offset  = gct_pkg::sweep_offset(step_use);
      step_d  = (step_use == gct_pkg::SearchLast) ? 6'd0 : step_use + 6'd1;
    end else begin
      jitter_d = ~jitter_q;
      unique case (phase_q)
        gct_pkg::PhaseContact: begin
          avert_d = '0;
          look_d  = look_sat;
          if (!contact) begin
            phase_d = gct_pkg::PhaseIdle;
          end else if (look_sat > cfg_i.look_time) begin
            phase_d = gct_pkg::PhaseAvert;
          end
        end
        gct_pkg::PhaseAvert: begin
          look_d  = '0;
          avert_d = avert_sat;
          offset  = gap;
          if (!contact) begin
            phase_d = gct_pkg::PhaseIdle;
          end else if (avert_sat > cfg_i.avert_time) begin
            phase_d = gct_pkg::PhaseContact;
          end
        end
        default: begin
          phase_d = contact ? gct_pkg::PhaseContact : gct_pkg::PhaseIdle;
        end
      endcase
    end
  end

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_q[i] <= '0;
      end
      sum_q    <= '0;
      phase_q  <= gct_pkg::PhaseIdle;
      look_q   <= '0;
      avert_q  <= '0;
      jitter_q <= 1'b0;
      step_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (item_pop_o) begin
        for (int i = 0; i < WINDOW; i++) begin
          win_q[i] <= win_d[i];
        end
        sum_q    <= sum_d;
        phase_q  <= phase_d;
        look_q   <= look_d;
        avert_q  <= avert_d;
        jitter_q <= jitter_d;
        step_q   <= step_d;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      phase_out_q <= phase_d;
      offset_q    <= offset;
      blink_q     <= obs_i.blink;
      vote_q      <= (32'(sum_d) > 32'd31) ? 5'd31 : 5'(sum_d);
      contact_q   <= contact;
    end
  end

  assign out_valid_o  = valid_q;
  assign phase_o      = phase_out_q;
  assign eye_offset_o = offset_q;
  assign blink_code_o = blink_q;
  assign vote_sum_o   = vote_q;
  assign contact_o    = contact_q;

endmodule

// File: hdl/gaze_contact_tracker.sv
// Gaze contact tracker.
// Input channel (in_valid_i/in_ready_o) takes one face observation per word;
// output channel (out_valid_o/out_ready_i) gives one result word per input word,
// in order. Settings are written over the APB port (pready always high);
// register i sits at byte address 4*i and reads back its value.
// A classifier scores the face and finds blink and face side in the cycle a
// word is accepted and writes it to a 2-entry queue. The tracker pops one word
// a cycle when the output register is free or drains, updates the score window,
// running sum, dwell counters and phase, and loads the output register; each word
// passes through a queue slot and then the output register.
// Throughput is one word per cycle while the receiver keeps up; the tracker update sets it.
// When the receiver stalls the output register holds, the queue fills, and
// in_ready_o drops once both queue entries are taken.
// Reset clears the window, phase, counters and queue, and loads the settings
// with their default values.
module gaze_contact_tracker #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gct_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // observation input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic signed [8:0]            face_yaw_i,
  input  logic signed [8:0]            gaze_yaw_i,
  input  logic [9:0]                   face_confidence_i,
  input  logic [9:0]                   gaze_confidence_i,
  input  logic [9:0]                   eye_a_openness_i,
  input  logic [9:0]                   eye_a_confidence_i,
  input  logic [9:0]                   eye_b_openness_i,
  input  logic [9:0]                   eye_b_confidence_i,
  input  logic [11:0]                  face_right_edge_i,
  input  logic [11:0]                  face_left_edge_i,
  input  logic [15:0]                  elapsed_ms_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   phase_o,
  output logic signed [9:0]            eye_offset_o,
  output logic [1:0]                   blink_code_o,
  output logic [4:0]                   vote_sum_o,
  output logic                         contact_o
);

  localparam int unsigned ScoreW = $clog2(WINDOW / 3 + 1);
  localparam int unsigned DataW  = $bits(gct_pkg::obs_t) + ScoreW;

  logic [9:0]  conf_thr_q;
  logic [7:0]  angle_tol_q;
  logic [9:0]  closed_lim_q;
  logic [15:0] look_time_q;
  logic [15:0] avert_time_q;
  logic [11:0] image_width_q;
  logic [8:0]  avert_offset_q;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  gct_pkg::front_cfg_t front_cfg;
  gct_pkg::back_cfg_t  back_cfg;
  gct_pkg::obs_t       obs_wr, obs_rd;
  logic [ScoreW-1:0]   score_wr, score_rd;
  logic [DataW-1:0]    q_rdata;
  logic                q_full, q_valid, q_pop, q_push;

  // register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q     <= 10'd100;
      angle_tol_q    <= 8'd7;
      closed_lim_q   <= 10'd200;
      look_time_q    <= 16'd2000;
      avert_time_q   <= 16'd500;
      image_width_q  <= 12'd640;
      avert_offset_q <= 9'd150;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gct_pkg::RegConfThr:     conf_thr_q     <= pwdata[9:0];
        gct_pkg::RegAngleTol:    angle_tol_q    <= pwdata[7:0];
        gct_pkg::RegClosedLim:   closed_lim_q   <= pwdata[9:0];
        gct_pkg::RegLookTime:    look_time_q    <= pwdata[15:0];
        gct_pkg::RegAvertTime:   avert_time_q   <= pwdata[15:0];
        gct_pkg::RegImageWidth:  image_width_q  <= pwdata[11:0];
        gct_pkg::RegAvertOffset: avert_offset_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      gct_pkg::RegConfThr:     prdata = {22'd0, conf_thr_q};
      gct_pkg::RegAngleTol:    prdata = {24'd0, angle_tol_q};
      gct_pkg::RegClosedLim:   prdata = {22'd0, closed_lim_q};
      gct_pkg::RegLookTime:    prdata = {16'd0, look_time_q};
      gct_pkg::RegAvertTime:   prdata = {16'd0, avert_time_q};
      gct_pkg::RegImageWidth:  prdata = {20'd0, image_width_q};
      gct_pkg::RegAvertOffset: prdata = {23'd0, avert_offset_q};
      default:                 prdata = '0;
    endcase
  end

  assign front_cfg.conf_thr    = conf_thr_q;
  assign front_cfg.angle_tol   = angle_tol_q;
  assign front_cfg.closed_lim  = closed_lim_q;
  assign front_cfg.image_width = image_width_q;
  assign back_cfg.look_time    = look_time_q;
  assign back_cfg.avert_time   = avert_time_q;
  assign back_cfg.avert_offset = avert_offset_q;

  // classifier
  gct_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .kind_i             (kind_i),
    .face_yaw_i         (face_yaw_i),
    .gaze_yaw_i         (gaze_yaw_i),
    .face_confidence_i  (face_confidence_i),
    .gaze_confidence_i  (gaze_confidence_i),
    .eye_a_openness_i   (eye_a_openness_i),
    .eye_a_confidence_i (eye_a_confidence_i),
    .eye_b_openness_i   (eye_b_openness_i),
    .eye_b_confidence_i (eye_b_confidence_i),
    .face_right_edge_i  (face_right_edge_i),
    .face_left_edge_i   (face_left_edge_i),
    .elapsed_ms_i       (elapsed_ms_i),
    .cfg_i              (front_cfg),
    .obs_o              (obs_wr),
    .score_o            (score_wr)
  );

  // queue between classifier and tracker
  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  gct_queue #(
    .DATA_W (DataW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({obs_wr, score_wr}),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  assign obs_rd   = gct_pkg::obs_t'(q_rdata[DataW-1:ScoreW]);
  assign score_rd = q_rdata[ScoreW-1:0];

  // tracker
  gct_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (back_cfg),
    .item_valid_i (q_valid),
    .obs_i        (obs_rd),
    .score_i      (score_rd),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phase_o      (phase_o),
    .eye_offset_o (eye_offset_o),
    .blink_code_o (blink_code_o),
    .vote_sum_o   (vote_sum_o),
    .contact_o    (contact_o)
  );

endmodule
